// ===== design/saa_pkg.sv =====
package saa_pkg;

   localparam int MAX_SIZE  = 256;
   localparam int MAX_LINES = 16;
   localparam int DIM_MAX   = 4096;

   // Heights up to MAX_SIZE fall into classes 2^0 .. 2^8.
   localparam int CLASS_COUNT = $clog2(MAX_SIZE) + 1;
   localparam int CLASS_W     = $clog2(CLASS_COUNT);
   localparam int LINE_W      = $clog2(MAX_LINES);
   localparam int COUNT_W     = $clog2(MAX_LINES + 1);
   localparam int SIZE_W      = $clog2(MAX_SIZE + 1);

   localparam int REQ_DIM_W = 12;
   localparam int DIM_W     = 13;
   localparam int TOP_W     = 14;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 2;

   localparam int TABLE_DEPTH = CLASS_COUNT * MAX_LINES;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int ENTRY_W     = 2 * DIM_W;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_REJECT = 2'd1,
      CMD_CLEAR  = 2'd2
   } cmd_op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_PLACED  = 2'd0,
      ST_INVALID = 2'd1,
      ST_NO_ROOM = 2'd2,
      ST_CLEARED = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      BK_IDLE = 2'd0,
      BK_SCAN = 2'd1,
      BK_OPEN = 2'd2
   } back_state_type;

   typedef struct packed {
      cmd_op_type          op;
      logic [CLASS_W-1:0]  cls;
      logic [SIZE_W-1:0]   w;
      logic [SIZE_W-1:0]   h;
   } cmd_type;

endpackage

// ===== design/saa_ram.sv =====
module saa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/saa_front.sv =====
module saa_front (
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_type,
   input  logic [saa_pkg::REQ_DIM_W-1:0]     req_rect_width,
   input  logic [saa_pkg::REQ_DIM_W-1:0]     req_rect_height,
   input  logic                              queue_ready,
   output logic                              queue_push,
   output saa_pkg::cmd_type                  queue_cmd
);

   // Class of a height h in 1..MAX_SIZE: the bit length of h - 1.
   function automatic logic [saa_pkg::CLASS_W-1:0] class_of(
      input logic [saa_pkg::SIZE_W-1:0] h
   );
      logic [saa_pkg::SIZE_W-1:0] hm1;
      logic [saa_pkg::CLASS_W-1:0] k;
      hm1 = h - saa_pkg::SIZE_W'(1);
      k = '0;
      for (int b = 0; b < saa_pkg::SIZE_W; b++) begin
         if (hm1[b]) begin
            k = saa_pkg::CLASS_W'(b + 1);
         end
      end
      return k;
   endfunction

   logic oversize;

   always_comb begin
      oversize = (req_rect_width > saa_pkg::REQ_DIM_W'(saa_pkg::MAX_SIZE))
              || (req_rect_height > saa_pkg::REQ_DIM_W'(saa_pkg::MAX_SIZE));

      queue_cmd.w   = req_rect_width[saa_pkg::SIZE_W-1:0];
      queue_cmd.h   = req_rect_height[saa_pkg::SIZE_W-1:0];
      queue_cmd.cls = class_of(req_rect_height[saa_pkg::SIZE_W-1:0]);

      if (req_type) begin
         queue_cmd.op = saa_pkg::CMD_CLEAR;
      end else if (oversize || (req_rect_height == '0)) begin
         queue_cmd.op = saa_pkg::CMD_REJECT;
      end else begin
         queue_cmd.op = saa_pkg::CMD_INSERT;
      end
   end

   assign req_ready  = queue_ready;
   assign queue_push = req_valid && queue_ready;

endmodule

// ===== design/saa_queue.sv =====
module saa_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  saa_pkg::cmd_type push_cmd,
   output logic             not_full,
   input  logic             pop,
   output logic             not_empty,
   output saa_pkg::cmd_type head_cmd
);

   saa_pkg::cmd_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign not_full  = (count_ff != 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head_cmd  = slot_ff[rd_ptr_ff];
   assign do_push   = push && not_full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== design/saa_back.sv =====
module saa_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            cmd_valid,
   input  saa_pkg::cmd_type                cmd,
   output logic                            cmd_pop,
   input  logic                            csr_write,
   input  logic [saa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [saa_pkg::DIM_W-1:0]       csr_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [saa_pkg::STATUS_W-1:0]    rsp_status,
   output logic [saa_pkg::DIM_W-1:0]       rsp_left,
   output logic [saa_pkg::DIM_W-1:0]       rsp_top,
   output logic [saa_pkg::TOP_W-1:0]       rsp_right,
   output logic [saa_pkg::TOP_W-1:0]       rsp_bottom
);

   function automatic logic [saa_pkg::ADDR_W-1:0] line_addr(
      input logic [saa_pkg::CLASS_W-1:0] cls,
      input logic [saa_pkg::LINE_W-1:0]  idx
   );
      return saa_pkg::ADDR_W'(saa_pkg::ADDR_W'(cls) * saa_pkg::ADDR_W'(saa_pkg::MAX_LINES)
                              + saa_pkg::ADDR_W'(idx));
   endfunction

   saa_pkg::back_state_type state_ff, state_in;
   saa_pkg::cmd_type        cmd_ff, cmd_in;
   logic [saa_pkg::COUNT_W-1:0] n_ff, n_in;
   logic [saa_pkg::LINE_W-1:0]  chk_ff, chk_in;
   logic [saa_pkg::TOP_W-1:0]   top_ff, top_in;
   logic [saa_pkg::COUNT_W-1:0] lpc_ff [saa_pkg::CLASS_COUNT];
   logic [saa_pkg::COUNT_W-1:0] lpc_in [saa_pkg::CLASS_COUNT];
   logic [saa_pkg::DIM_W-1:0]   image_width_ff, image_width_in;
   logic [saa_pkg::DIM_W-1:0]   image_height_ff, image_height_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   saa_pkg::status_type         rsp_status_ff, rsp_status_in;
   logic [saa_pkg::DIM_W-1:0]   rsp_left_ff, rsp_left_in;
   logic [saa_pkg::DIM_W-1:0]   rsp_top_ff, rsp_top_in;
   logic [saa_pkg::TOP_W-1:0]   rsp_right_ff, rsp_right_in;
   logic [saa_pkg::TOP_W-1:0]   rsp_bottom_ff, rsp_bottom_in;
   logic                        load_rsp;

   logic                        ram_wr_en, ram_rd_en;
   logic [saa_pkg::ADDR_W-1:0]  ram_wr_addr, ram_rd_addr;
   logic [saa_pkg::ENTRY_W-1:0] ram_wr_data, ram_rd_data;

   logic [saa_pkg::DIM_W-1:0]   line_fill, line_y, room_w, fill_sum, csr_value;
   logic [saa_pkg::TOP_W-1:0]   room_h;
   logic                        rsp_free;

   saa_ram #(
      .WIDTH(saa_pkg::ENTRY_W),
      .DEPTH(saa_pkg::TABLE_DEPTH)
   ) u_line_table (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // Each table entry holds the line's y in the upper half and its filled width below.
   assign line_y    = ram_rd_data[saa_pkg::ENTRY_W-1:saa_pkg::DIM_W];
   assign line_fill = ram_rd_data[saa_pkg::DIM_W-1:0];
   assign room_w    = (image_width_ff > line_fill) ? image_width_ff - line_fill : '0;
   assign fill_sum  = line_fill + saa_pkg::DIM_W'(cmd_ff.w);
   assign room_h    = (saa_pkg::TOP_W'(image_height_ff) > top_ff)
                    ? saa_pkg::TOP_W'(image_height_ff) - top_ff : '0;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign csr_value = (csr_data > saa_pkg::DIM_W'(saa_pkg::DIM_MAX))
                    ? saa_pkg::DIM_W'(saa_pkg::DIM_MAX) : csr_data;

   always_comb begin
      state_in        = state_ff;
      cmd_in          = cmd_ff;
      n_in            = n_ff;
      chk_in          = chk_ff;
      top_in          = top_ff;
      lpc_in          = lpc_ff;
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      cmd_pop         = 1'b0;
      ram_wr_en       = 1'b0;
      ram_wr_addr     = line_addr(cmd_ff.cls, chk_ff);
      ram_wr_data     = {line_y, fill_sum};
      ram_rd_en       = 1'b0;
      ram_rd_addr     = line_addr(cmd.cls, '0);
      load_rsp        = 1'b0;
      rsp_status_in   = saa_pkg::ST_PLACED;
      rsp_left_in     = '0;
      rsp_top_in      = '0;
      rsp_right_in    = '0;
      rsp_bottom_in   = '0;

      if (csr_write) begin
         unique case (csr_index)
            saa_pkg::CSR_IMAGE_WIDTH:  image_width_in  = csr_value;
            saa_pkg::CSR_IMAGE_HEIGHT: image_height_in = csr_value;
            default: ;
         endcase
      end

      unique case (state_ff)
         saa_pkg::BK_IDLE: begin
            if (cmd_valid && rsp_free) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd;
               unique case (cmd.op)
                  saa_pkg::CMD_CLEAR: begin
                     for (int c = 0; c < saa_pkg::CLASS_COUNT; c++) begin
                        lpc_in[c] = '0;
                     end
                     top_in        = '0;
                     load_rsp      = 1'b1;
                     rsp_status_in = saa_pkg::ST_CLEARED;
                  end
                  saa_pkg::CMD_INSERT: begin
                     n_in      = lpc_ff[cmd.cls];
                     chk_in    = '0;
                     ram_rd_en = (lpc_ff[cmd.cls] != '0);
                     state_in  = (lpc_ff[cmd.cls] != '0) ? saa_pkg::BK_SCAN
                                                         : saa_pkg::BK_OPEN;
                  end
                  default: begin
                     load_rsp      = 1'b1;
                     rsp_status_in = saa_pkg::ST_INVALID;
                  end
               endcase
            end
         end

         saa_pkg::BK_SCAN: begin
            // The line read last cycle is checked while the next one is fetched.
            if (saa_pkg::DIM_W'(cmd_ff.w) <= room_w) begin
               ram_wr_en     = 1'b1;
               load_rsp      = 1'b1;
               rsp_status_in = saa_pkg::ST_PLACED;
               rsp_left_in   = line_fill;
               rsp_top_in    = line_y;
               rsp_right_in  = saa_pkg::TOP_W'(line_fill) + saa_pkg::TOP_W'(cmd_ff.w);
               rsp_bottom_in = saa_pkg::TOP_W'(line_y) + saa_pkg::TOP_W'(cmd_ff.h);
               state_in      = saa_pkg::BK_IDLE;
            end else if (saa_pkg::COUNT_W'(chk_ff) + saa_pkg::COUNT_W'(1) == n_ff) begin
               state_in = saa_pkg::BK_OPEN;
            end else begin
               chk_in      = chk_ff + saa_pkg::LINE_W'(1);
               ram_rd_en   = 1'b1;
               ram_rd_addr = line_addr(cmd_ff.cls, chk_ff + saa_pkg::LINE_W'(1));
            end
         end

         saa_pkg::BK_OPEN: begin
            load_rsp = 1'b1;
            state_in = saa_pkg::BK_IDLE;
            if ((n_ff == saa_pkg::COUNT_W'(saa_pkg::MAX_LINES))
                || (saa_pkg::TOP_W'(cmd_ff.h) > room_h)) begin
               rsp_status_in = saa_pkg::ST_NO_ROOM;
            end else begin
               ram_wr_en            = 1'b1;
               ram_wr_addr          = line_addr(cmd_ff.cls, n_ff[saa_pkg::LINE_W-1:0]);
               ram_wr_data          = {top_ff[saa_pkg::DIM_W-1:0],
                                       saa_pkg::DIM_W'(cmd_ff.w)};
               lpc_in[cmd_ff.cls]   = n_ff + saa_pkg::COUNT_W'(1);
               rsp_status_in        = saa_pkg::ST_PLACED;
               rsp_top_in           = top_ff[saa_pkg::DIM_W-1:0];
               rsp_right_in         = saa_pkg::TOP_W'(cmd_ff.w);
               rsp_bottom_in        = top_ff + saa_pkg::TOP_W'(cmd_ff.h);
               top_in               = top_ff + (saa_pkg::TOP_W'(1) << cmd_ff.cls);
            end
         end

         default: state_in = saa_pkg::BK_IDLE;
      endcase

      rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= saa_pkg::BK_IDLE;
         top_ff          <= '0;
         image_width_ff  <= saa_pkg::DIM_W'(1024);
         image_height_ff <= saa_pkg::DIM_W'(1024);
         rsp_valid_ff    <= 1'b0;
         for (int c = 0; c < saa_pkg::CLASS_COUNT; c++) begin
            lpc_ff[c] <= '0;
         end
      end else begin
         state_ff        <= state_in;
         top_ff          <= top_in;
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
         rsp_valid_ff    <= rsp_valid_in;
         lpc_ff          <= lpc_in;
      end
      cmd_ff <= cmd_in;
      n_ff   <= n_in;
      chk_ff <= chk_in;
      if (load_rsp) begin
         rsp_status_ff <= rsp_status_in;
         rsp_left_ff   <= rsp_left_in;
         rsp_top_ff    <= rsp_top_in;
         rsp_right_ff  <= rsp_right_in;
         rsp_bottom_ff <= rsp_bottom_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_left   = rsp_left_ff;
   assign rsp_top    = rsp_top_ff;
   assign rsp_right  = rsp_right_ff;
   assign rsp_bottom = rsp_bottom_ff;

endmodule

// ===== design/shelf_atlas_allocator_unit.sv =====
// Channel     Direction  Beat carries
// req_        in         req_type, req_rect_width, req_rect_height
// rsp_        out        rsp_status, rsp_left, rsp_top, rsp_right, rsp_bottom
// csr_        in         csr_index, csr_data (image width or height)
//
// A clear or a rejected size is handled in the back end's idle state alone; an insert
// examines the lines of its class one at a time (up to 16) through the line table's
// read port, and tries to open a new line when none of them has room for it.
// Requests are classified on entry and wait in a two-beat queue; req_ready drops only
// once two beats wait behind the one in the back end or a result that is not yet taken.
// Synchronous reset; no clearing pass is needed, the first beat may follow at once.
module shelf_atlas_allocator_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_type,
   input  logic [saa_pkg::REQ_DIM_W-1:0]   req_rect_width,
   input  logic [saa_pkg::REQ_DIM_W-1:0]   req_rect_height,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [saa_pkg::STATUS_W-1:0]    rsp_status,
   output logic [saa_pkg::DIM_W-1:0]       rsp_left,
   output logic [saa_pkg::DIM_W-1:0]       rsp_top,
   output logic [saa_pkg::TOP_W-1:0]       rsp_right,
   output logic [saa_pkg::TOP_W-1:0]       rsp_bottom,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [saa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [saa_pkg::DIM_W-1:0]       csr_data
);

   logic             queue_ready, queue_push, queue_pop, queue_valid;
   saa_pkg::cmd_type front_cmd, head_cmd;

   assign csr_ready = 1'b1;

   saa_front u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_rect_width (req_rect_width),
      .req_rect_height(req_rect_height),
      .queue_ready    (queue_ready),
      .queue_push     (queue_push),
      .queue_cmd      (front_cmd)
   );

   saa_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (queue_push),
      .push_cmd (front_cmd),
      .not_full (queue_ready),
      .pop      (queue_pop),
      .not_empty(queue_valid),
      .head_cmd (head_cmd)
   );

   saa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (queue_valid),
      .cmd       (head_cmd),
      .cmd_pop   (queue_pop),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_status(rsp_status),
      .rsp_left  (rsp_left),
      .rsp_top   (rsp_top),
      .rsp_right (rsp_right),
      .rsp_bottom(rsp_bottom)
   );

endmodule

// ===== design/saa_checker.sv =====
module saa_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [saa_pkg::STATUS_W-1:0]    rsp_status,
   input logic [saa_pkg::DIM_W-1:0]       rsp_left,
   input logic [saa_pkg::DIM_W-1:0]       rsp_top,
   input logic [saa_pkg::TOP_W-1:0]       rsp_right,
   input logic [saa_pkg::TOP_W-1:0]       rsp_bottom
);

   // A result beat that is not taken must hold.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_left)
         && $stable(rsp_top) && $stable(rsp_right) && $stable(rsp_bottom))
      else $error("result beat changed while stalled");

   // Only a placement carries corners.
   a_zero_corners: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != saa_pkg::ST_PLACED) |->
         (rsp_left == '0) && (rsp_top == '0) && (rsp_right == '0) && (rsp_bottom == '0))
      else $error("non-placement result with corners");

   // A placed rectangle is at least one row high and no taller than the largest class.
   a_placed_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == saa_pkg::ST_PLACED) |->
         (rsp_right >= saa_pkg::TOP_W'(rsp_left))
         && (rsp_bottom > saa_pkg::TOP_W'(rsp_top))
         && (rsp_bottom - saa_pkg::TOP_W'(rsp_top) <= saa_pkg::TOP_W'(saa_pkg::MAX_SIZE)))
      else $error("placed rectangle has impossible corners");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered straight after reset");

endmodule

bind shelf_atlas_allocator_unit saa_checker u_saa_checker (.*);
